>>> rtl/core/efc_pkg.sv
// Types, codes and constants shared by the elevator floor controller modules.
`default_nettype none
package efc_pkg;

    localparam logic [1:0] ACT_KEY   = 2'd0;
    localparam logic [1:0] ACT_PULSE = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;
    localparam logic [1:0] ACT_STEP  = 2'd3;

    localparam logic [1:0] MODE_DOWN = 2'd0;
    localparam logic [1:0] MODE_UP   = 2'd1;
    localparam logic [1:0] MODE_STOP = 2'd2;

    localparam logic [1:0] REG_TOP_FLOOR   = 2'd0;
    localparam logic [1:0] REG_HOME_FLOOR  = 2'd1;
    localparam logic [1:0] REG_PULSES      = 2'd2;
    localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd3;

    localparam logic [3:0]  RST_TOP_FLOOR    = 4'd9;
    localparam logic [3:0]  RST_HOME_FLOOR   = 4'd5;
    localparam logic [3:0]  RST_PULSES       = 4'd3;
    localparam logic [15:0] RST_IDLE_TIMEOUT = 16'd3000;
    localparam logic [3:0]  RST_FLOOR_NOW    = 4'd1;
    localparam logic [3:0]  RST_FLOOR_GOAL   = 4'd7;
    localparam logic [3:0]  MIN_TOP_FLOOR    = 4'd2;
    localparam logic [15:0] TICKS_MAX        = 16'hFFFF;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] floor_key;
    } in_t;

    typedef struct packed {
        logic [3:0] coils;
        logic       door_open;
        logic [1:0] direction;
        logic [3:0] current_floor;
        logic [3:0] target_floor;
        logic       direction_changed;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [3:0]  top_floor;
        logic [3:0]  home_floor;
        logic [3:0]  pulses_per_floor;
        logic [15:0] idle_timeout;
    } cfg_t;

    function automatic logic [7:0] fwd_pattern(input logic [1:0] phase);
        logic [7:0] pat;
        case (phase)
            2'd0:    pat = 8'h8C;
            2'd1:    pat = 8'h46;
            2'd2:    pat = 8'h23;
            default: pat = 8'h19;
        endcase
        return pat;
    endfunction

    function automatic logic [7:0] rev_pattern(input logic [1:0] phase);
        logic [7:0] pat;
        case (phase)
            2'd0:    pat = 8'h13;
            2'd1:    pat = 8'h26;
            2'd2:    pat = 8'h4C;
            default: pat = 8'h89;
        endcase
        return pat;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/elevator_floor_controller.sv
// Top level of the elevator floor controller with stepper half-step drive.
// Results of a request are written into the result queue registers when it is taken.
// Throughput: one request per cycle for key, sensor, tick and stopping requests
// while in_stall is low; a stepping request gives two results, which leave one at
// a time through the single output port of the four-entry result queue.
// Reset: configuration to defaults, car at floor 1 heading for 7, queue empty.
`default_nettype none
module elevator_floor_controller
    import efc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_t         in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_t             out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t cfg;
    out_t res_first;
    out_t res_second;
    logic res_pair;
    logic accept;
    logic pop;
    logic room;

    assign cfg_ready = 1'b1;
    assign in_stall  = !room;
    assign accept    = in_valid && room;
    assign pop       = out_valid && !out_stall;

    efc_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cfg_valid && cfg_ready),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    efc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req        (in_data),
        .cfg        (cfg),
        .res_first  (res_first),
        .res_second (res_second),
        .res_pair   (res_pair)
    );

    efc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_two  (res_pair),
        .item_a    (res_first),
        .item_b    (res_second),
        .pop       (pop),
        .head      (out_data),
        .not_empty (out_valid),
        .room      (room)
    );

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last |=> out_valid && out_data.last)
        else $error("second half-step result missing");

    a_door_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.door_open |-> out_data.direction == MODE_STOP)
        else $error("door open while car not stopped");

    a_step_moving: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> out_data.direction != MODE_STOP && !out_data.door_open)
        else $error("half-step result while stopped");

endmodule
`default_nettype wire

>>> rtl/core/efc_regs.sv
// Configuration register file of the elevator floor controller.
`default_nettype none
module efc_regs
    import efc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr,
    input  wire logic [1:0]  index,
    input  wire logic [15:0] data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.top_floor        <= RST_TOP_FLOOR;
            cfg_reg.home_floor       <= RST_HOME_FLOOR;
            cfg_reg.pulses_per_floor <= RST_PULSES;
            cfg_reg.idle_timeout     <= RST_IDLE_TIMEOUT;
        end
        else if (wr)
        begin
            case (index)
                REG_TOP_FLOOR:    cfg_reg.top_floor        <= data[3:0];
                REG_HOME_FLOOR:   cfg_reg.home_floor       <= data[3:0];
                REG_PULSES:       cfg_reg.pulses_per_floor <= data[3:0];
                REG_IDLE_TIMEOUT: cfg_reg.idle_timeout     <= data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

>>> rtl/core/efc_core.sv
// Car state and result formation for one request of the elevator floor controller.
`default_nettype none
module efc_core
    import efc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic accept,
    input  wire in_t  req,
    input  wire cfg_t cfg,
    output out_t      res_first,
    output out_t      res_second,
    output logic      res_pair
);

    logic [3:0]  floor_now_reg,  floor_now_next;
    logic [3:0]  floor_goal_reg, floor_goal_next;
    logic [3:0]  pulse_count_reg, pulse_count_next;
    logic [1:0]  run_mode_reg,   run_mode_next;
    logic [1:0]  prior_mode_reg, prior_mode_next;
    logic        waiting_reg,    waiting_next;
    logic [15:0] wait_ticks_reg, wait_ticks_next;
    logic [1:0]  up_phase_reg,   up_phase_next;
    logic [1:0]  down_phase_reg, down_phase_next;
    logic        door_reg,       door_next;

    logic [3:0] top;
    logic [3:0] home;
    logic [3:0] pulse_inc;
    logic [7:0] pattern;
    logic       timed_out;
    logic       changed;

    always_comb
    begin
        top = (cfg.top_floor < MIN_TOP_FLOOR) ? MIN_TOP_FLOOR : cfg.top_floor;
        if (cfg.home_floor == 4'd0)
            home = 4'd1;
        else if (cfg.home_floor > top)
            home = top;
        else
            home = cfg.home_floor;
        pulse_inc = pulse_count_reg + 4'd1;
        timed_out = (wait_ticks_reg >= cfg.idle_timeout);

        floor_now_next   = floor_now_reg;
        floor_goal_next  = floor_goal_reg;
        pulse_count_next = pulse_count_reg;
        run_mode_next    = run_mode_reg;
        prior_mode_next  = prior_mode_reg;
        waiting_next     = waiting_reg;
        wait_ticks_next  = wait_ticks_reg;
        up_phase_next    = up_phase_reg;
        down_phase_next  = down_phase_reg;
        door_next        = door_reg;
        pattern          = 8'h00;
        res_pair         = 1'b0;

        case (req.action)
            ACT_KEY:
            begin
                if ((req.floor_key != 4'd0) && (req.floor_key <= top))
                begin
                    floor_goal_next = req.floor_key;
                    waiting_next    = 1'b0;
                    wait_ticks_next = '0;
                end
            end
            ACT_PULSE:
            begin
                if (pulse_inc >= cfg.pulses_per_floor)
                begin
                    pulse_count_next = '0;
                    if (run_mode_reg == MODE_DOWN)
                        floor_now_next = (floor_now_reg <= 4'd1) ? 4'd1
                                                                 : floor_now_reg - 4'd1;
                    else if (run_mode_reg == MODE_UP)
                        floor_now_next = (floor_now_reg >= top) ? top
                                                                : floor_now_reg + 4'd1;
                end
                else
                begin
                    pulse_count_next = pulse_inc;
                end
            end
            ACT_TICK:
            begin
                if (waiting_reg && (wait_ticks_reg != TICKS_MAX))
                    wait_ticks_next = wait_ticks_reg + 16'd1;
            end
            default:
            begin
                prior_mode_next = run_mode_reg;
                if (floor_now_reg == floor_goal_reg)
                begin
                    if (timed_out)
                        floor_goal_next = home;
                    if (timed_out || !waiting_reg)
                        wait_ticks_next = '0;
                    run_mode_next = MODE_STOP;
                    waiting_next  = 1'b1;
                    door_next     = 1'b1;
                end
                else
                begin
                    res_pair  = 1'b1;
                    door_next = 1'b0;
                    if (floor_now_reg < floor_goal_reg)
                    begin
                        run_mode_next = MODE_UP;
                        pattern       = fwd_pattern(up_phase_reg);
                        up_phase_next = up_phase_reg + 2'd1;
                    end
                    else
                    begin
                        run_mode_next   = MODE_DOWN;
                        pattern         = rev_pattern(down_phase_reg);
                        down_phase_next = down_phase_reg + 2'd1;
                    end
                end
            end
        endcase

        changed = (req.action == ACT_STEP) && (run_mode_next != run_mode_reg);

        res_first.coils             = res_pair ? pattern[7:4] : 4'd0;
        res_first.door_open         = door_next;
        res_first.direction         = run_mode_next;
        res_first.current_floor     = floor_now_next;
        res_first.target_floor      = floor_goal_next;
        res_first.direction_changed = changed;
        res_first.last              = !res_pair;

        res_second       = res_first;
        res_second.coils = pattern[3:0];
        res_second.last  = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_now_reg   <= RST_FLOOR_NOW;
            floor_goal_reg  <= RST_FLOOR_GOAL;
            pulse_count_reg <= '0;
            run_mode_reg    <= MODE_UP;
            prior_mode_reg  <= MODE_UP;
            waiting_reg     <= 1'b0;
            wait_ticks_reg  <= '0;
            up_phase_reg    <= '0;
            down_phase_reg  <= '0;
            door_reg        <= 1'b0;
        end
        else if (accept)
        begin
            floor_now_reg   <= floor_now_next;
            floor_goal_reg  <= floor_goal_next;
            pulse_count_reg <= pulse_count_next;
            run_mode_reg    <= run_mode_next;
            prior_mode_reg  <= prior_mode_next;
            waiting_reg     <= waiting_next;
            wait_ticks_reg  <= wait_ticks_next;
            up_phase_reg    <= up_phase_next;
            down_phase_reg  <= down_phase_next;
            door_reg        <= door_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/efc_queue.sv
// Result register queue that takes one or two results per request.
`default_nettype none
module efc_queue
    import efc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire logic push_two,
    input  wire out_t item_a,
    input  wire out_t item_b,
    input  wire logic pop,
    output out_t      head,
    output logic      not_empty,
    output logic      room
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    out_t               mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [PTR_W-1:0]   wr_ptr_b;
    logic               second;

    always_comb
    begin
        second      = push && push_two;
        wr_ptr_b    = wr_ptr_reg + PTR_W'(1);
        wr_ptr_next = wr_ptr_reg + PTR_W'(push) + PTR_W'(second);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg + CNT_W'(push) + CNT_W'(second) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= item_a;
        if (second)
            mem[wr_ptr_b] <= item_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign room      = (cnt_reg <= CNT_W'(DEPTH - 2));

endmodule
`default_nettype wire
